[rtl/core/c8core_pkg.sv]
// Shared types, constants and font table for the instruction core.
package c8core_pkg;

   localparam int ADDR_W = 12;
   localparam int ROW_W  = 5;
   localparam int COLS   = 64;
   localparam int ROWS   = 32;
   localparam logic [11:0] PROGRAM_START = 12'h200;
   localparam logic [11:0] FONT_BASE     = 12'h050;
   localparam int FONT_BYTES = 80;
   localparam logic [15:0] OP_CLS = 16'h00E0;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_EXEC  = 2'd1,
      FUNC_ROW   = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_MEMRD, ST_FETCH_HI, ST_FETCH_LO, ST_DECODE,
      ST_CLEAR, ST_DRAW_RD, ST_DRAW_WAIT, ST_DRAW_WR, ST_ROWRD, ST_OUT
   } state_type;

   typedef struct packed {
      logic [11:0] program_counter;
      logic [15:0] fetched_opcode;
      logic [63:0] row_pixels;
      logic [7:0]  mem_read_data;
      logic        collision;
   } rsp_type;

   function automatic logic [7:0] font_byte(input logic [6:0] idx);
      logic [7:0] f [0:79];
      f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
            8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
            8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
            8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
            8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
            8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
            8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
            8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
      if (idx < 7'(FONT_BYTES)) begin
         return f[idx];
      end
      return 8'h00;
   endfunction

endpackage

[rtl/core/c8core_ram.sv]
// Generic single-port RAM with registered read.
module c8core_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/core/c8core_regs.sv]
// Register file V0..VF, flop based with a clearing reset.
module c8core_regs (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [3:0] wr_idx,
   input  logic [7:0] wr_data,
   input  logic [3:0] rd_idx_a,
   input  logic [3:0] rd_idx_b,
   output logic [7:0] rd_a,
   output logic [7:0] rd_b
);
   logic [7:0] v_ff [16];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            v_ff[i] <= '0;
         end
      end else if (wr_en) begin
         v_ff[wr_idx] <= wr_data;
      end
   end

   assign rd_a = v_ff[rd_idx_a];
   assign rd_b = v_ff[rd_idx_b];
endmodule

[rtl/core/chip8_instruction_core.sv]
// Instruction core top level: sequencer around main memory and frame buffer.
// A write goes from idle straight to output; memory and row reads pass one read state;
// instructions fetch two bytes and decode; clear walks every row; draw reads, waits and writes per sprite row.
// One item at a time; the memory port and frame buffer port set the pace.
// After reset a pass over every memory address writes zero and the font into main memory
// and clears the frame buffer alongside; no item is accepted until it ends.
module chip8_instruction_core #(
   parameter int MEM_BYTES   = 4096,
   parameter int SCREEN_COLS = 64,
   parameter int SCREEN_ROWS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,  // func[1:0], mem_address[13:2], mem_write_data[21:14], row_select[26:22]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata   // program_counter[11:0], fetched_opcode[27:12], row_pixels[91:28], mem_read_data[99:92], collision[100]
);
   import c8core_pkg::*;

   localparam int MA_W = $clog2(MEM_BYTES);
   localparam int FR_W = $clog2(SCREEN_ROWS);

   state_type st_ff, st_in;
   logic [MA_W-1:0] cnt_ff, cnt_in;
   logic [11:0] pc_ff, pc_in, i_ff, i_in;
   logic [15:0] op_ff, op_in;
   logic [1:0]  func_ff, func_in;
   logic [11:0] addr_ff, addr_in;
   logic [7:0]  wd_ff, wd_in;
   logic [4:0]  rsel_ff, rsel_in;
   logic [3:0]  r_ff, r_in;
   logic [7:0]  px_ff, px_in, py_ff, py_in;
   logic        hit_ff, hit_in;
   logic [63:0] sprite_ff, sprite_in;
   rsp_type     out_ff, out_in;
   logic        ov_ff, ov_in;

   logic        m_we;
   logic [MA_W-1:0] m_addr;
   logic [7:0]  m_wd, m_rd;
   logic        f_we;
   logic [FR_W-1:0] f_addr;
   logic [63:0] f_wd, f_rd;
   logic        v_we;
   logic [3:0]  v_idx;
   logic [7:0]  v_wd, vx, vy;

   c8core_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock, .wr_en(m_we), .addr(m_addr), .wr_data(m_wd), .rd_data(m_rd));
   c8core_ram #(.WIDTH(SCREEN_COLS), .DEPTH(SCREEN_ROWS)) u_fb (
      .clock, .wr_en(f_we), .addr(f_addr), .wr_data(f_wd), .rd_data(f_rd));
   c8core_regs u_regs (
      .clock, .reset, .wr_en(v_we), .wr_idx(v_idx), .wr_data(v_wd),
      .rd_idx_a(op_ff[11:8]), .rd_idx_b(op_ff[7:4]), .rd_a(vx), .rd_b(vy));

   logic accept;
   assign req_tready = (st_ff == ST_IDLE) && !ov_ff;
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {3'd0, out_ff.collision, out_ff.mem_read_data, out_ff.row_pixels,
                       out_ff.fetched_opcode, out_ff.program_counter};

   logic [8:0] ydraw;
   assign ydraw = {1'b0, py_ff} + {5'd0, r_ff};

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_INIT:      if (cnt_ff == MA_W'(MEM_BYTES - 1)) st_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               case (func_type'(req_tdata[1:0]))
                  FUNC_WRITE: st_in = ST_OUT;
                  FUNC_EXEC:  st_in = ST_FETCH_HI;
                  FUNC_ROW:   st_in = ST_ROWRD;
                  default:    st_in = ST_MEMRD;
               endcase
            end
         end
         ST_MEMRD:     st_in = ST_OUT;
         ST_ROWRD:     st_in = ST_OUT;
         ST_FETCH_HI:  st_in = ST_FETCH_LO;
         ST_FETCH_LO:  st_in = ST_DECODE;
         ST_DECODE: begin
            if (op_ff == OP_CLS) st_in = ST_CLEAR;
            else if (op_ff[15:12] == 4'hD) st_in = ST_DRAW_RD;
            else st_in = ST_OUT;
         end
         ST_CLEAR:     if (cnt_ff[FR_W-1:0] == FR_W'(SCREEN_ROWS - 1)) st_in = ST_OUT;
         ST_DRAW_RD: begin
            if ({1'b0, r_ff} >= {1'b0, op_ff[3:0]} || ydraw >= 9'(SCREEN_ROWS))
               st_in = ST_OUT;
            else st_in = ST_DRAW_WAIT;
         end
         ST_DRAW_WAIT: st_in = ST_DRAW_WR;
         ST_DRAW_WR:   st_in = ST_DRAW_RD;
         ST_OUT:       st_in = ST_IDLE;
         default:      st_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      logic [MA_W-1:0] fa;
      logic [63:0] sp;
      cnt_in = cnt_ff; pc_in = pc_ff; i_in = i_ff; op_in = op_ff;
      func_in = func_ff; addr_in = addr_ff; wd_in = wd_ff; rsel_in = rsel_ff;
      r_in = r_ff; px_in = px_ff; py_in = py_ff; hit_in = hit_ff;
      sprite_in = sprite_ff; out_in = out_ff;
      ov_in = ov_ff && !rsp_tready;
      m_we = 1'b0; m_addr = addr_ff[MA_W-1:0]; m_wd = wd_ff;
      f_we = 1'b0; f_addr = rsel_ff[FR_W-1:0]; f_wd = '0;
      v_we = 1'b0; v_idx = op_ff[11:8]; v_wd = '0;
      fa = cnt_ff - MA_W'(FONT_BASE);
      sp = '0;
      case (st_ff)
         ST_INIT: begin
            m_we = 1'b1; m_addr = cnt_ff; m_wd = font_byte(fa[6:0]);
            if (cnt_ff < MA_W'(FONT_BASE) ||
                cnt_ff >= MA_W'(FONT_BASE) + MA_W'(FONT_BYTES)) m_wd = '0;
            f_we = 1'b1; f_addr = cnt_ff[FR_W-1:0];
            cnt_in = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            func_in = req_tdata[1:0]; addr_in = req_tdata[13:2];
            wd_in = req_tdata[21:14]; rsel_in = req_tdata[26:22];
            m_addr = req_tdata[MA_W+1:2]; m_wd = req_tdata[21:14];
            f_addr = req_tdata[FR_W+21:22];
            cnt_in = '0; r_in = '0; hit_in = 1'b0;
            if (accept) begin
               if (func_type'(req_tdata[1:0]) == FUNC_WRITE) m_we = 1'b1;
               if (func_type'(req_tdata[1:0]) == FUNC_EXEC) m_addr = pc_ff[MA_W-1:0];
            end
         end
         ST_FETCH_HI: begin
            m_addr = MA_W'(pc_ff + 12'd1);
            op_in[15:8] = m_rd;
         end
         ST_FETCH_LO: op_in[7:0] = m_rd;
         ST_DECODE: begin
            pc_in = pc_ff + 12'd2;
            case (op_ff[15:12])
               4'h1: pc_in = op_ff[11:0];
               4'h3: if (vx == op_ff[7:0]) pc_in = pc_ff + 12'd4;
               4'h4: if (vx != op_ff[7:0]) pc_in = pc_ff + 12'd4;
               4'h5: if (op_ff[3:0] == 4'h0 && vx == vy) pc_in = pc_ff + 12'd4;
               4'h9: if (vx != vy) pc_in = pc_ff + 12'd4;
               4'h6: begin v_we = 1'b1; v_wd = op_ff[7:0]; end
               4'h7: begin v_we = 1'b1; v_wd = vx + op_ff[7:0]; end
               4'hA: i_in = op_ff[11:0];
               4'hD: begin
                  px_in = vx; py_in = vy;
                  v_we = 1'b1; v_idx = 4'hF; v_wd = '0;
               end
               default: ;
            endcase
         end
         ST_CLEAR: begin
            f_we = 1'b1; f_addr = cnt_ff[FR_W-1:0]; cnt_in = cnt_ff + 1'b1;
         end
         ST_DRAW_RD: begin
            m_addr = MA_W'(i_ff + {8'd0, r_ff});
            f_addr = ydraw[FR_W-1:0];
         end
         ST_DRAW_WAIT: begin
            f_addr = ydraw[FR_W-1:0];
            if (px_ff < 8'(SCREEN_COLS)) begin
               sp = {m_rd, 56'd0} >> px_ff[5:0];
            end
            sprite_in = sp;
         end
         ST_DRAW_WR: begin
            f_we = 1'b1; f_addr = ydraw[FR_W-1:0];
            f_wd = f_rd ^ sprite_ff;
            if ((f_rd & sprite_ff) != '0) hit_in = 1'b1;
            r_in = r_ff + 1'b1;
         end
         ST_OUT: begin
            out_in.program_counter = pc_ff;
            out_in.fetched_opcode = op_ff;
            out_in.row_pixels = (func_ff == FUNC_ROW) ? f_rd : '0;
            out_in.mem_read_data = (func_ff == FUNC_READ) ? m_rd : '0;
            out_in.collision = 1'b0;
            if (func_ff == FUNC_EXEC && op_ff[15:12] == 4'hD) begin
               out_in.collision = hit_ff;
               v_we = 1'b1; v_idx = 4'hF; v_wd = {7'd0, hit_ff};
            end
            ov_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_INIT; cnt_ff <= '0; pc_ff <= PROGRAM_START;
         i_ff <= '0; op_ff <= '0; ov_ff <= 1'b0; hit_ff <= 1'b0; r_ff <= '0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; pc_ff <= pc_in; i_ff <= i_in;
         op_ff <= op_in; ov_ff <= ov_in; hit_ff <= hit_in; r_ff <= r_in;
      end
      func_ff <= func_in; addr_ff <= addr_in; wd_ff <= wd_in; rsel_ff <= rsel_in;
      px_ff <= px_in; py_ff <= py_in; sprite_ff <= sprite_in; out_ff <= out_in;
   end

   assert property (@(posedge clock) disable iff (reset) accept |=> st_ff != ST_IDLE)
      else $error("item accepted but sequencer stayed idle");
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("new item taken while result pending");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_OUT) |=> rsp_tvalid)
      else $error("result not presented");
endmodule

[tb/chip8_instruction_core_tb.sv]
// Testbench for the instruction core: directed programs and random items checked against a predictor.
`timescale 1ns / 100ps
module chip8_instruction_core_tb;
   import c8core_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;

   chip8_instruction_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   typedef struct {
      logic [11:0] pc;
      logic [15:0] opcode;
      logic [63:0] pixels;
      logic [7:0]  rdata;
      logic        coll;
   } core_result;

   // predictor state
   logic [7:0]  mem_model [0:4095];
   logic [7:0]  vreg [0:15];
   logic [11:0] ireg;
   logic [11:0] pc_model;
   logic [15:0] op_model;
   logic [63:0] screen [0:31];

   core_result result_queue[$];
   int  mismatch_count = 0;
   int  hold_off_cycles = 0;
   bit  rsp_random = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   task automatic model_reset();
      for (int a = 0; a < 4096; a++) mem_model[a] = 8'h00;
      for (int a = 0; a < FONT_BYTES; a++) mem_model[FONT_BASE + a] = font_byte(7'(a));
      for (int r = 0; r < 16; r++) vreg[r] = 8'h00;
      for (int r = 0; r < 32; r++) screen[r] = 64'h0;
      ireg = 12'h000;
      pc_model = PROGRAM_START;
      op_model = 16'h0000;
   endtask

   function automatic logic sprite_draw(input logic [3:0] x, input logic [3:0] y,
                                        input logic [3:0] n);
      int px, py, yy, xx;
      logic [7:0] bits;
      logic hit;
      px = vreg[x];
      py = vreg[y];
      hit = 1'b0;
      vreg[15] = 8'h00;
      for (int r = 0; r < n; r++) begin
         yy = py + r;
         if (yy >= 32) break;
         bits = mem_model[12'(ireg + r)];
         for (int c = 0; c < 8; c++) begin
            xx = px + c;
            if (xx >= 64) break;
            if (bits[7-c]) begin
               if (screen[yy][63-xx]) hit = 1'b1;
               screen[yy][63-xx] = ~screen[yy][63-xx];
            end
         end
      end
      vreg[15] = {7'd0, hit};
      return hit;
   endfunction

   function automatic logic exec_instruction();
      logic [15:0] op;
      logic [3:0] x, y, n;
      logic [7:0] nn;
      logic coll;
      op = {mem_model[pc_model], mem_model[12'(pc_model + 1)]};
      op_model = op;
      pc_model = pc_model + 12'd2;
      x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0];
      coll = 1'b0;
      case (op[15:12])
         4'h0: if (op == OP_CLS) for (int r = 0; r < 32; r++) screen[r] = 64'h0;
         4'h1: pc_model = op[11:0];
         4'h3: if (vreg[x] == nn) pc_model = pc_model + 12'd2;
         4'h4: if (vreg[x] != nn) pc_model = pc_model + 12'd2;
         4'h5: if (n == 4'h0 && vreg[x] == vreg[y]) pc_model = pc_model + 12'd2;
         4'h9: if (vreg[x] != vreg[y]) pc_model = pc_model + 12'd2;
         4'h6: vreg[x] = nn;
         4'h7: vreg[x] = vreg[x] + nn;
         4'hA: ireg = op[11:0];
         4'hD: coll = sprite_draw(x, y, n);
         default: ;
      endcase
      return coll;
   endfunction

   function automatic core_result predict_item(input func_type f, input logic [11:0] addr,
                                               input logic [7:0] wdata, input logic [4:0] row);
      core_result res;
      res.pixels = 64'h0;
      res.rdata = 8'h00;
      res.coll = 1'b0;
      case (f)
         FUNC_WRITE: mem_model[addr] = wdata;
         FUNC_EXEC:  res.coll = exec_instruction();
         FUNC_ROW:   res.pixels = screen[row];
         default:    res.rdata = mem_model[addr];
      endcase
      res.pc = pc_model;
      res.opcode = op_model;
      return res;
   endfunction

   // send one item; gap drawn per item, valid stays high across back-to-back items
   task automatic send_item(input func_type f, input logic [11:0] addr = 12'h0,
                            input logic [7:0] wdata = 8'h0, input logic [4:0] row = 5'h0);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, row, wdata, addr, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      result_queue.push_back(predict_item(f, addr, wdata, row));
   endtask

   task automatic write_op(input logic [11:0] addr, input logic [15:0] op);
      send_item(FUNC_WRITE, addr, op[15:8]);
      send_item(FUNC_WRITE, 12'(addr + 1), op[7:0]);
   endtask

   // result checker
   always @(posedge clock) begin
      core_result want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (result_queue.size() == 0) begin
            report("unexpected item", rsp_tdata[63:0], 64'h0);
         end else begin
            want = result_queue.pop_front();
            if (rsp_tdata[11:0] !== want.pc) report("program_counter", rsp_tdata[11:0], want.pc);
            if (rsp_tdata[27:12] !== want.opcode)
               report("fetched_opcode", rsp_tdata[27:12], want.opcode);
            if (rsp_tdata[91:28] !== want.pixels) report("row_pixels", rsp_tdata[91:28], want.pixels);
            if (rsp_tdata[99:92] !== want.rdata) report("mem_read_data", rsp_tdata[99:92], want.rdata);
            if (rsp_tdata[100] !== want.coll) report("collision", rsp_tdata[100], want.coll);
         end
      end
   end

   // receiver stalls
   initial begin
      int wait_cycles;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else if (!rsp_random) begin
            rsp_tready <= 1'b1;
         end else begin
            wait_cycles = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
            if (wait_cycles > 0) begin
               rsp_tready <= 1'b0;
               repeat (wait_cycles) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            @(posedge clock);
            while (!rsp_tvalid) @(posedge clock);
         end
      end
   end

   task automatic test_memory();
      send_item(FUNC_READ, FONT_BASE);
      send_item(FUNC_READ, 12'h09F);
      send_item(FUNC_READ, 12'hFFF);
      send_item(FUNC_WRITE, 12'hFFF, 8'hFF);
      send_item(FUNC_READ, 12'hFFF);
      send_item(FUNC_WRITE, 12'h000, 8'hA5);
      send_item(FUNC_READ, 12'h000);
      send_item(FUNC_ROW, 12'h0, 8'h0, 5'd31);
   endtask

   task automatic test_opcodes();
      logic [15:0] prog [$];
      prog = '{16'h6A05, 16'h7AFF, 16'h3A04, 16'h0000, 16'h4A04, 16'h0000,
               16'h6B04, 16'h5AB0, 16'h0000, 16'h5AB1, 16'h9AB7, 16'h0000,
               16'hA050, 16'h6000, 16'h6100, 16'hD015, 16'hD015, 16'h603C,
               16'h611E, 16'hD01F, 16'hD010, 16'h00E0, 16'h0123, 16'h1FFE};
      for (int k = 0; k < prog.size(); k++) write_op(12'(12'h200 + 2*k), prog[k]);
      write_op(12'hFFE, 16'h6050);
      for (int k = 0; k < 22; k++) send_item(FUNC_EXEC);
      send_item(FUNC_ROW, 12'h0, 8'h0, 5'd0);
      send_item(FUNC_ROW, 12'h0, 8'h0, 5'd31);
      send_item(FUNC_EXEC);
      send_item(FUNC_EXEC);
      send_item(FUNC_EXEC);
      send_item(FUNC_ROW, 12'h0, 8'h0, 5'd0);
   endtask

   // long receiver hold-off while the sender keeps going
   task automatic test_backpressure();
      hold_off_cycles = 400;
      for (int k = 0; k < 20; k++) send_item(FUNC_READ, 12'($urandom_range(0, 4095)));
   endtask

   function automatic logic [15:0] random_opcode();
      logic [15:0] op;
      op = 16'($urandom);
      case ($urandom_range(0, 11))
         0: op = OP_CLS;
         1: op = {4'h1, 12'h200 | 12'($urandom_range(0, 127))};
         2: op = {4'hD, op[11:0]};
         3: op = {4'hA, op[11:0]};
         4: op = {4'h6, op[11:0]};
         5: op = {4'h7, op[11:0]};
         6: op = {4'h3, op[11:0]};
         7: op = {4'h4, op[11:0]};
         8: op = {4'h5, op[11:0]};
         9: op = {4'h9, op[11:0]};
         10: op = {4'hD, op[11:4], 4'($urandom_range(1, 15))};
         default: ;
      endcase
      return op;
   endfunction

   task automatic test_random();
      int sent;
      sent = 0;
      while (sent < 1790) begin
         // load a short program at PC, run it, then probe rows and read or write memory
         for (int k = 0; k < 8; k++) begin
            write_op(12'(pc_model + 2*k), random_opcode());
            sent += 2;
         end
         repeat ($urandom_range(4, 12)) begin
            send_item(FUNC_EXEC);
            sent++;
         end
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
               0: send_item(FUNC_ROW, 12'($urandom), 8'($urandom), 5'($urandom));
               1: send_item(FUNC_READ, 12'($urandom));
               default: send_item(FUNC_WRITE, 12'($urandom), 8'($urandom));
            endcase
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      model_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_memory();
      test_opcodes();
      test_backpressure();
      test_random();
      req_tvalid <= 1'b0;
      rsp_random = 1'b0;
      while (result_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && result_queue.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[chip8_instruction_core.f]
rtl/core/c8core_pkg.sv
rtl/core/c8core_ram.sv
rtl/core/c8core_regs.sv
rtl/core/chip8_instruction_core.sv
tb/chip8_instruction_core_tb.sv
